// ===== rtl/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants for the Euler-to-rotation-matrix block
// Angle reduction constants, CORDIC arctangent table and front/back record.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int TrigFrac     = 30;
  localparam int CordicStages = 18;
  localparam int FullTurn     = 23040;
  localparam int QuarterTurn  = 5760;
  localparam int AngleW       = 16;
  localparam int RemW         = 13;
  localparam int ZW           = 26;
  localparam int TrigW        = 33;
  localparam logic signed [TrigW-1:0] CordicK = 33'sd652032874;
  localparam logic signed [TrigW-1:0] TrigOne = 33'sd1073741824;

  typedef logic signed [TrigW-1:0] trig_t;

  // Reduced angle: quadrant, remainder and exact-axis flag.
  typedef struct packed {
    logic [1:0]      quad;
    logic [RemW-1:0] rem;
    logic            axis;
  } red_ang_t;

  typedef struct packed {
    red_ang_t roll;
    red_ang_t pitch;
    red_ang_t yaw;
  } red_item_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int idx);
    logic signed [ZW-1:0] v;
    begin
      unique case (idx)
        0: v = 26'sd11796480;
        1: v = 26'sd6963869;
        2: v = 26'sd3679517;
        3: v = 26'sd1867780;
        4: v = 26'sd937515;
        5: v = 26'sd469214;
        6: v = 26'sd234664;
        7: v = 26'sd117339;
        8: v = 26'sd58671;
        9: v = 26'sd29335;
        10: v = 26'sd14668;
        11: v = 26'sd7334;
        12: v = 26'sd3667;
        13: v = 26'sd1833;
        14: v = 26'sd917;
        15: v = 26'sd458;
        16: v = 26'sd229;
        default: v = 26'sd115;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/e2r_front.sv =====
// ----------------------------------------------------------------------------
// e2r_front: angle reduction
// Wraps each angle modulo 360 degrees and splits it into quadrant and remainder.
// ----------------------------------------------------------------------------
module e2r_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [e2r_pkg::AngleW-1:0] roll_deg_i,
  input  logic signed [e2r_pkg::AngleW-1:0] pitch_deg_i,
  input  logic signed [e2r_pkg::AngleW-1:0] yaw_deg_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output e2r_pkg::red_item_t                item_o
);

  function automatic e2r_pkg::red_ang_t reduce(input logic signed [15:0] a);
    logic signed [17:0] r;
    logic [14:0] u;
    e2r_pkg::red_ang_t o;
    begin
      // |a| <= 32768 < 2*23040: at most two corrections
      r = 18'(a);
      if (r < 0) r = r + 18'sd23040;
      if (r < 0) r = r + 18'sd23040;
      if (r >= 18'sd23040) r = r - 18'sd23040;
      u = r[14:0];
      if (u >= 15'd17280) begin
        o.quad = 2'd3; u = u - 15'd17280;
      end else if (u >= 15'd11520) begin
        o.quad = 2'd2; u = u - 15'd11520;
      end else if (u >= 15'd5760) begin
        o.quad = 2'd1; u = u - 15'd5760;
      end else begin
        o.quad = 2'd0;
      end
      o.rem  = u[12:0];
      o.axis = (u == 15'd0);
      return o;
    end
  endfunction

  logic               valid_q;
  e2r_pkg::red_item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q.roll  <= reduce(roll_deg_i);
      item_q.pitch <= reduce(pitch_deg_i);
      item_q.yaw   <= reduce(yaw_deg_i);
    end
  end

endmodule

// ===== rtl/e2r_queue.sv =====
// ----------------------------------------------------------------------------
// e2r_queue: two-entry queue between front and back
// Decouples angle reduction from the trig and matrix pipeline.
// ----------------------------------------------------------------------------
module e2r_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  e2r_pkg::red_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output e2r_pkg::red_item_t item_o
);

  e2r_pkg::red_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

`ifndef NO_ASSERTIONS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("queue count after pop");
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count after push");
`endif

endmodule

// ===== rtl/e2r_back.sv =====
// ----------------------------------------------------------------------------
// e2r_back: CORDIC and matrix pipeline
// 18 CORDIC stages for three angles, quadrant map, products and output rounding.
// ----------------------------------------------------------------------------
module e2r_back #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  e2r_pkg::red_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o
);

  localparam int NS = e2r_pkg::CordicStages;
  localparam int ZW = e2r_pkg::ZW;
  localparam int SH = e2r_pkg::TrigFrac - OUT_FRAC_BITS;
  // stages: 0 load, 1..NS cordic, NS+1 map, NS+2 prod1, NS+3 prod2, NS+4 sum, NS+5 out
  localparam int NP = NS + 6;

  typedef logic signed [e2r_pkg::TrigW-1:0] tw_t;
  typedef struct packed {
    tw_t x; tw_t y; logic signed [ZW-1:0] z; logic [1:0] quad; logic axis;
  } cst_t;

  function automatic tw_t rnd30(input tw_t a, input tw_t b);
    logic signed [65:0] p;
    begin
      p = 66'(a) * 66'(b) + 66'sd536870912;
      return tw_t'(p >>> 30);
    end
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [34:0] v);
    logic signed [34:0] t;
    logic signed [34:0] lim;
    begin
      t = v;
      if (SH > 0) t = (v + (35'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      lim = 35'sd1 <<< OUT_FRAC_BITS;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      if (t > 35'sd32767) t = 35'sd32767;
      if (t < -35'sd32768) t = -35'sd32768;
      return t[15:0];
    end
  endfunction

  logic [NP-1:0] vld_q;
  logic          adv;
  assign adv     = !vld_q[NP-1] || ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q[NP-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NP-2:0], valid_i};
    end
  end

  cst_t cs_q [3][NS+1];
  e2r_pkg::red_ang_t in_a [3];
  assign in_a[0] = item_i.roll;
  assign in_a[1] = item_i.pitch;
  assign in_a[2] = item_i.yaw;

  tw_t c_q [3], s_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_ang
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cs_q[k][0].x    <= e2r_pkg::CordicK;
        cs_q[k][0].y    <= '0;
        cs_q[k][0].z    <= ZW'(in_a[k].rem) <<< 12;
        cs_q[k][0].quad <= in_a[k].quad;
        cs_q[k][0].axis <= in_a[k].axis;
      end
    end
    for (genvar i = 0; i < NS; i++) begin : g_st
      always_ff @(posedge clk_i) begin
        if (adv) begin
          cs_q[k][i+1].quad <= cs_q[k][i].quad;
          cs_q[k][i+1].axis <= cs_q[k][i].axis;
          if (cs_q[k][i].z >= 0) begin
            cs_q[k][i+1].x <= cs_q[k][i].x - (cs_q[k][i].y >>> i);
            cs_q[k][i+1].y <= cs_q[k][i].y + (cs_q[k][i].x >>> i);
            cs_q[k][i+1].z <= cs_q[k][i].z - e2r_pkg::atan_tab(i);
          end else begin
            cs_q[k][i+1].x <= cs_q[k][i].x + (cs_q[k][i].y >>> i);
            cs_q[k][i+1].y <= cs_q[k][i].y - (cs_q[k][i].x >>> i);
            cs_q[k][i+1].z <= cs_q[k][i].z + e2r_pkg::atan_tab(i);
          end
        end
      end
    end
    tw_t xc, yc;
    always_comb begin
      xc = cs_q[k][NS].x;
      yc = cs_q[k][NS].y;
      if (xc > e2r_pkg::TrigOne) xc = e2r_pkg::TrigOne;
      if (xc < -e2r_pkg::TrigOne) xc = -e2r_pkg::TrigOne;
      if (yc > e2r_pkg::TrigOne) yc = e2r_pkg::TrigOne;
      if (yc < -e2r_pkg::TrigOne) yc = -e2r_pkg::TrigOne;
      if (cs_q[k][NS].axis) begin
        xc = e2r_pkg::TrigOne;
        yc = '0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        unique case (cs_q[k][NS].quad)
          2'd1: begin c_q[k] <= -yc; s_q[k] <= xc; end
          2'd2: begin c_q[k] <= -xc; s_q[k] <= -yc; end
          2'd3: begin c_q[k] <= yc; s_q[k] <= -xc; end
          default: begin c_q[k] <= xc; s_q[k] <= yc; end
        endcase
      end
    end
  end

  // first products
  tw_t czy_q, szy_q, p00_q, p10_q, p21_q, p22_q, szcx_q, szsx_q, czcx_q, czsx_q;
  tw_t sx1_q, cx1_q, nsy1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      czy_q  <= rnd30(c_q[2], s_q[1]);
      szy_q  <= rnd30(s_q[2], s_q[1]);
      p00_q  <= rnd30(c_q[2], c_q[1]);
      p10_q  <= rnd30(s_q[2], c_q[1]);
      p21_q  <= rnd30(c_q[1], s_q[0]);
      p22_q  <= rnd30(c_q[1], c_q[0]);
      szcx_q <= rnd30(s_q[2], c_q[0]);
      szsx_q <= rnd30(s_q[2], s_q[0]);
      czcx_q <= rnd30(c_q[2], c_q[0]);
      czsx_q <= rnd30(c_q[2], s_q[0]);
      sx1_q  <= s_q[0];
      cx1_q  <= c_q[0];
      nsy1_q <= -s_q[1];
    end
  end

  // second products
  tw_t a01_q, a02_q, a11_q, a12_q;
  tw_t b00_q, b10_q, b21_q, b22_q, b01_q, b02_q, b11_q, b12_q, b20_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a01_q <= rnd30(czy_q, sx1_q);
      a02_q <= rnd30(czy_q, cx1_q);
      a11_q <= rnd30(szy_q, sx1_q);
      a12_q <= rnd30(szy_q, cx1_q);
      b01_q <= szcx_q; b02_q <= szsx_q; b11_q <= czcx_q; b12_q <= czsx_q;
      b00_q <= p00_q; b10_q <= p10_q; b21_q <= p21_q; b22_q <= p22_q;
      b20_q <= nsy1_q;
    end
  end

  logic signed [34:0] e_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q[0] <= 35'(b00_q);
      e_q[1] <= 35'(a01_q) - 35'(b01_q);
      e_q[2] <= 35'(a02_q) + 35'(b02_q);
      e_q[3] <= 35'(b10_q);
      e_q[4] <= 35'(a11_q) + 35'(b11_q);
      e_q[5] <= 35'(a12_q) - 35'(b12_q);
      e_q[6] <= 35'(b20_q);
      e_q[7] <= 35'(b21_q);
      e_q[8] <= 35'(b22_q);
    end
  end

  logic signed [15:0] o_q [9];
  for (genvar j = 0; j < 9; j++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (adv) o_q[j] <= to_out(e_q[j]);
    end
  end

  assign m00_o = o_q[0];
  assign m01_o = o_q[1];
  assign m02_o = o_q[2];
  assign m10_o = o_q[3];
  assign m11_o = o_q[4];
  assign m12_o = o_q[5];
  assign m20_o = o_q[6];
  assign m21_o = o_q[7];
  assign m22_o = o_q[8];

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(m00_o) && $stable(m22_o)))
    else $error("result changed while stalled");
  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (m00_o <= 16'sd32767 && m00_o >= -16'sd32768))
    else $error("diagonal out of range");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv) |=> (vld_q == $past(vld_q)))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ===== rtl/euler_to_rotation_matrix.sv =====
// Path: angle reduction register, then the two-entry queue, then the trig and matrix pipeline.
// Output stalls hold the back pipeline, and then the queue, until ready returns.
// Throughput: one angle triple per cycle while the output is not stalled, set by the fully pipelined 18-stage CORDIC.
// Reset: asynchronous, active low; clears all valid flags and the queue pointers and count only.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: Z-Y-X Euler angles to 3x3 rotation matrix
// Front reduces angles, a short queue decouples it, back computes R = Rz*Ry*Rx.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] roll_deg_i,
  input  logic signed [15:0] pitch_deg_i,
  input  logic signed [15:0] yaw_deg_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  e2r_pkg::red_item_t f_item, b_item;

  e2r_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .roll_deg_i, .pitch_deg_i, .yaw_deg_i,
    .valid_o(f_valid), .ready_i(f_ready), .item_o(f_item)
  );

  e2r_queue u_queue (
    .clk_i, .rst_ni, .valid_i(f_valid), .ready_o(f_ready), .item_i(f_item),
    .valid_o(b_valid), .ready_i(b_ready), .item_o(b_item)
  );

  e2r_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(b_valid), .ready_o(b_ready), .item_i(b_item),
    .valid_o, .ready_i,
    .m00_o, .m01_o, .m02_o, .m10_o, .m11_o, .m12_o, .m20_o, .m21_o, .m22_o
  );

endmodule

// ===== verif/tb_euler_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix: self-checking bench for the Euler-to-matrix block
// Sends angle triples over valid/ready and checks each of the nine Q1.14
// elements against a bit-exact CORDIC and rounding predictor, under random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix;

  localparam int OutFrac = 14;
  localparam int Latency = 30;

  typedef logic signed [15:0] elem_t;
  typedef struct packed {
    elem_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
  } matrix_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  valid_i = 1'b0;
  logic  ready_o;
  elem_t roll_i = '0, pitch_i = '0, yaw_i = '0;
  logic  valid_o;
  logic  ready_i = 1'b0;
  elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_t matrix_q[$];
  int      mismatches = 0;
  int      sent = 0;
  int      checked = 0;
  int      stall_cycles = 0;
  bit      calm = 1'b0;

  euler_to_rotation_matrix #(.OUT_FRAC_BITS(OutFrac)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(valid_i), .ready_o(ready_o),
    .roll_deg_i(roll_i), .pitch_deg_i(pitch_i), .yaw_deg_i(yaw_i),
    .valid_o(valid_o), .ready_i(ready_i),
    .m00_o(m00), .m01_o(m01), .m02_o(m02),
    .m10_o(m10), .m11_o(m11), .m12_o(m12),
    .m20_o(m20), .m21_o(m21), .m22_o(m22)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint atan_step(input int idx);
    longint t[18] = '{11796480, 6963869, 3679517, 1867780, 937515, 469214,
                      234664, 117339, 58671, 29335, 14668, 7334,
                      3667, 1833, 917, 458, 229, 115};
    return t[idx];
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void sin_cos(input elem_t ang, output longint c, output longint s);
    longint r, q, rem, x, y, z, dx, dy;
    longint one;
    one = 64'sd1 << 30;
    r = longint'(ang) % 23040;
    if (r < 0) r += 23040;
    q = r / 5760;
    rem = r - q * 5760;
    if (rem == 0) begin
      x = one;
      y = 0;
    end else begin
      x = 652032874;
      y = 0;
      z = rem * 4096;
      for (int i = 0; i < 18; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step(i);
        end else begin
          x += dx; y -= dy; z += atan_step(i);
        end
      end
      x = clip(x, -one, one);
      y = clip(y, -one, one);
    end
    case (q)
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic elem_t to_q14(input longint v);
    longint lim;
    lim = 64'sd1 << OutFrac;
    v = (v + (64'sd1 << (29 - OutFrac))) >>> (30 - OutFrac);
    v = clip(clip(v, -lim, lim), -32768, 32767);
    return elem_t'(v);
  endfunction

  function automatic matrix_t rotation(input elem_t rx, input elem_t ry, input elem_t rz);
    longint cx, sx, cy, sy, cz, sz, czy, szy;
    matrix_t m;
    sin_cos(rx, cx, sx);
    sin_cos(ry, cy, sy);
    sin_cos(rz, cz, sz);
    czy = qmul(cz, sy);
    szy = qmul(sz, sy);
    m.e00 = to_q14(qmul(cz, cy));
    m.e01 = to_q14(qmul(czy, sx) - qmul(sz, cx));
    m.e02 = to_q14(qmul(czy, cx) + qmul(sz, sx));
    m.e10 = to_q14(qmul(sz, cy));
    m.e11 = to_q14(qmul(szy, sx) + qmul(cz, cx));
    m.e12 = to_q14(qmul(szy, cx) - qmul(cz, sx));
    m.e20 = to_q14(-sy);
    m.e21 = to_q14(qmul(cy, sx));
    m.e22 = to_q14(qmul(cy, cx));
    return m;
  endfunction

  task automatic send_angles(input elem_t rx, input elem_t ry, input elem_t rz);
    while (!calm && $urandom_range(99) < 18) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    roll_i  <= rx;
    pitch_i <= ry;
    yaw_i   <= rz;
    matrix_q.push_back(rotation(rx, ry, rz));
    sent++;
    do @(posedge clk_i); while (!ready_o);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || stall_cycles > 0) begin
      ready_i <= 1'b0;
      if (stall_cycles > 0) stall_cycles <= stall_cycles - 1;
    end else begin
      ready_i <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && valid_o && ready_i) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      checked++;
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = matrix_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic elem_t rand_angle();
    case ($urandom_range(9))
      0: return elem_t'($urandom);
      1: return elem_t'(5760 * $signed($urandom_range(8)) - 23040);
      2: return elem_t'(5760 * $signed($urandom_range(8)) - 23040 + $signed($urandom_range(2)) - 1);
      default: return elem_t'($signed($urandom_range(46080)) - 23040);
    endcase
  endfunction

  task automatic test_extremes();
    elem_t v[14] = '{0, 23040, -23040, 5760, -5760, 11520, 17280, 1, -1, 5759,
                     16'sh7fff, 16'sh8000, 2880, -2880};
    foreach (v[i]) send_angles(v[i], v[(i + 3) % 14], v[(i + 7) % 14]);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sh5555, 16'shaaaa, 16'sh0f0f);
    send_angles(16'shaaaa, 16'sh5555, 16'shf0f0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_backpressure();
    stall_cycles = 200;
    test_random(60);
  endtask

  task automatic test_streaming();
    calm = 1'b1;
    test_random(150);
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random(300);
    test_backpressure();
    test_streaming();
    test_random(340);
    valid_i <= 1'b0;
    wait (matrix_q.size() == 0);
    repeat (Latency) @(posedge clk_i);
    $display("covered %0d angle triples, %0d matrices checked, incl. axis poses,", sent, checked);
    $display("wraparound patterns, a long output stall and back-to-back streaming");
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
